// ===== hw/rtl/vdcd_pkg.sv =====
// Package for the vector draw command decoder: opcodes, tool codes,
// command codes and the result record shared by the core and the top level.
// Depends on nothing.
package vdcd_pkg;

  localparam int unsigned CODE_W = 8;
  localparam int unsigned ARG_W  = 6;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned OUT_W  = 32;

  localparam logic [1:0] OP_DX   = 2'd0;
  localparam logic [1:0] OP_DY   = 2'd1;
  localparam logic [1:0] OP_DATA = 2'd2;
  localparam logic [1:0] OP_TOOL = 2'd3;

  localparam logic [ARG_W-1:0] TOOL_PEN    = 6'd0;
  localparam logic [ARG_W-1:0] TOOL_PAUSE  = 6'd1;
  localparam logic [ARG_W-1:0] TOOL_CLEAR  = 6'd2;
  localparam logic [ARG_W-1:0] TOOL_KEY    = 6'd3;
  localparam logic [ARG_W-1:0] TOOL_COLOUR = 6'd4;

  localparam logic [CMD_W-1:0] CMD_LINE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PAUSE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_KEY    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COLOUR = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [OUT_W-1:0] x_start;
    logic signed [OUT_W-1:0] y_start;
    logic signed [OUT_W-1:0] x_end;
    logic signed [OUT_W-1:0] y_end;
    logic [OUT_W-1:0]        value;
  } result_t;

endpackage

// ===== hw/rtl/vdcd_byte_if.sv =====
// Input channel of the vector draw command decoder: one command byte per item.
// Depends on vdcd_pkg.
interface vdcd_byte_if;
  logic                         valid;
  logic                         ready;
  logic [vdcd_pkg::CODE_W-1:0]  code_byte;

  modport source(output valid, output code_byte, input ready);
  modport sink(input valid, input code_byte, output ready);
endinterface

// ===== hw/rtl/vdcd_result_if.sv =====
// Result channel of the vector draw command decoder: one drawing action per item.
// Depends on vdcd_pkg.
interface vdcd_result_if;
  logic                                valid;
  logic                                ready;
  logic [vdcd_pkg::CMD_W-1:0]          command;
  logic signed [vdcd_pkg::OUT_W-1:0]   x_start;
  logic signed [vdcd_pkg::OUT_W-1:0]   y_start;
  logic signed [vdcd_pkg::OUT_W-1:0]   x_end;
  logic signed [vdcd_pkg::OUT_W-1:0]   y_end;
  logic [vdcd_pkg::OUT_W-1:0]          value;

  modport source(output valid, output command, output x_start, output y_start,
                 output x_end, output y_end, output value, input ready);
  modport sink(input valid, input command, input x_start, input y_start,
               input x_end, input y_end, input value, output ready);
endinterface

// ===== hw/rtl/vector_draw_command_decoder_unit.sv =====
// Top level of the vector draw command decoder: input register, decoder core
// and result register. Depends on vdcd_pkg, vdcd_byte_if, vdcd_result_if, vdcd_core.
//
//   Channel   Direction  Payload                                        Handshake
//   in_byte   sink       code_byte[7:0]                                 valid/ready
//   out_res   source     command, x_start, y_start, x_end, y_end, value valid/ready
//
// One item is taken per cycle unless a held result stalls the input register; a byte
// is held in the input register and its action, if any, then in the result register.
// All state updates happen as the byte leaves the input register.
// Reset is synchronous and clears both register valids and the core state.
// A held result stalls only a byte that produces a result; other bytes pass it.
module vector_draw_command_decoder_unit #(
  parameter int unsigned MAX_DATA_BYTES = 10,
  parameter int unsigned COORD_WIDTH    = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  vdcd_byte_if.sink      in_byte,
  vdcd_result_if.source  out_res
);

  logic                        s1_v_r;
  logic [vdcd_pkg::CODE_W-1:0] s1_byte_r;
  logic                        out_v_r;
  vdcd_pkg::result_t           out_r;
  logic                        emit;
  vdcd_pkg::result_t           result;
  logic                        adv;

  vdcd_core #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES),
    .COORD_WIDTH    (COORD_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .code_byte (s1_byte_r),
    .emit      (emit),
    .result    (result)
  );

  assign adv           = s1_v_r && (!out_v_r || out_res.ready || !emit);
  assign in_byte.ready = !s1_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_byte.ready) begin
      s1_v_r <= in_byte.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_byte.valid && in_byte.ready) begin
      s1_byte_r <= in_byte.code_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && emit) begin
      out_v_r <= 1'b1;
    end else if (out_res.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_r <= result;
    end
  end

  assign out_res.valid   = out_v_r;
  assign out_res.command = out_r.command;
  assign out_res.x_start = out_r.x_start;
  assign out_res.y_start = out_r.y_start;
  assign out_res.x_end   = out_r.x_end;
  assign out_res.y_end   = out_r.y_end;
  assign out_res.value   = out_r.value;

endmodule

// ===== hw/rtl/vdcd_core.sv =====
// Decoder core: cursor, step, pen, operand accumulator and pause state, and the
// combinational decode of one command byte into the next state and a result.
// Depends on vdcd_pkg.
module vdcd_core #(
  parameter int unsigned MAX_DATA_BYTES = 10,
  parameter int unsigned COORD_WIDTH    = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic [vdcd_pkg::CODE_W-1:0] code_byte,
  output logic                        emit,
  output vdcd_pkg::result_t           result
);

  localparam int unsigned ACC_W  = 6 * MAX_DATA_BYTES;
  localparam int unsigned RAW_W  = ACC_W + vdcd_pkg::ARG_W;
  localparam int unsigned SW     = (RAW_W > COORD_WIDTH) ? RAW_W : COORD_WIDTH;
  localparam int unsigned SIDX_W = $clog2(SW);
  localparam int unsigned CNT_W  = $clog2(MAX_DATA_BYTES + 1);

  logic [COORD_WIDTH-1:0]         pos_x_r, pos_y_r, step_x_r;
  logic [COORD_WIDTH-1:0]         pos_x_nxt, pos_y_nxt, step_x_nxt;
  logic                           pen_r, pen_nxt;
  logic [ACC_W-1:0]               acc_r, acc_nxt;
  logic                           started_r, started_nxt;
  logic [CNT_W-1:0]               bytes_r, bytes_nxt;
  logic [vdcd_pkg::OUT_W-1:0]     pause_r, pause_nxt;

  logic [1:0]                     op;
  logic [vdcd_pkg::ARG_W-1:0]     arg;
  logic [SW-1:0]                  ext_in, ext_out;
  logic [SIDX_W-1:0]              sidx;
  logic                           sign_bit;
  logic [COORD_WIDTH-1:0]         step_val;
  logic [COORD_WIDTH-1:0]         new_x, new_y;

  assign op  = code_byte[7:6];
  assign arg = code_byte[5:0];

  // Accumulated operand sign-extended at its own length.
  assign ext_in   = SW'({acc_r, arg});
  assign sidx     = SIDX_W'(bytes_r) * SIDX_W'(6) + SIDX_W'(5);
  assign sign_bit = ext_in[sidx];

  always_comb begin
    for (int i = 0; i < SW; i++) begin
      ext_out[i] = (SIDX_W'(i) <= sidx) ? ext_in[i] : sign_bit;
    end
  end

  always_comb begin
    if (!started_r) begin
      step_val = COORD_WIDTH'($signed(arg));
    end else if (acc_r == '0) begin
      step_val = COORD_WIDTH'(arg);
    end else begin
      step_val = ext_out[COORD_WIDTH-1:0];
    end
  end

  assign new_x = pos_x_r + step_x_r;
  assign new_y = pos_y_r + step_val;

  always_comb begin
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    step_x_nxt  = step_x_r;
    pen_nxt     = pen_r;
    acc_nxt     = acc_r;
    started_nxt = started_r;
    bytes_nxt   = bytes_r;
    pause_nxt   = pause_r;
    emit        = 1'b0;
    result      = '0;
    unique case (op)
      vdcd_pkg::OP_DX: begin
        step_x_nxt  = step_val;
        acc_nxt     = '0;
        started_nxt = 1'b0;
        bytes_nxt   = '0;
      end
      vdcd_pkg::OP_DY: begin
        acc_nxt     = '0;
        started_nxt = 1'b0;
        bytes_nxt   = '0;
        pos_x_nxt   = new_x;
        pos_y_nxt   = new_y;
        step_x_nxt  = '0;
        if (pen_r) begin
          emit           = 1'b1;
          result.command = vdcd_pkg::CMD_LINE;
          result.x_start = vdcd_pkg::OUT_W'($signed(pos_x_r));
          result.y_start = vdcd_pkg::OUT_W'($signed(pos_y_r));
          result.x_end   = vdcd_pkg::OUT_W'($signed(new_x));
          result.y_end   = vdcd_pkg::OUT_W'($signed(new_y));
        end
      end
      vdcd_pkg::OP_DATA: begin
        if (bytes_r < CNT_W'(MAX_DATA_BYTES)) begin
          acc_nxt     = ACC_W'({acc_r, arg});
          bytes_nxt   = bytes_r + CNT_W'(1);
          started_nxt = 1'b1;
        end
      end
      vdcd_pkg::OP_TOOL: begin
        unique case (arg)
          vdcd_pkg::TOOL_PEN: begin
            pen_nxt = !pen_r;
          end
          vdcd_pkg::TOOL_PAUSE: begin
            if (acc_r != '0) begin
              pause_nxt = vdcd_pkg::OUT_W'(acc_r);
            end
            acc_nxt        = '0;
            started_nxt    = 1'b0;
            bytes_nxt      = '0;
            emit           = 1'b1;
            result.command = vdcd_pkg::CMD_PAUSE;
            result.value   = (acc_r != '0) ? vdcd_pkg::OUT_W'(acc_r) : pause_r;
          end
          vdcd_pkg::TOOL_CLEAR: begin
            emit           = 1'b1;
            result.command = vdcd_pkg::CMD_CLEAR;
          end
          vdcd_pkg::TOOL_KEY: begin
            emit           = 1'b1;
            result.command = vdcd_pkg::CMD_KEY;
          end
          vdcd_pkg::TOOL_COLOUR: begin
            acc_nxt        = '0;
            started_nxt    = 1'b0;
            bytes_nxt      = '0;
            emit           = 1'b1;
            result.command = vdcd_pkg::CMD_COLOUR;
            result.value   = vdcd_pkg::OUT_W'(acc_r);
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      step_x_r  <= '0;
      pen_r     <= 1'b0;
      acc_r     <= '0;
      started_r <= 1'b0;
      bytes_r   <= '0;
      pause_r   <= '0;
    end else if (adv) begin
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
      step_x_r  <= step_x_nxt;
      pen_r     <= pen_nxt;
      acc_r     <= acc_nxt;
      started_r <= started_nxt;
      bytes_r   <= bytes_nxt;
      pause_r   <= pause_nxt;
    end
  end

endmodule
